@@ rtl/gswc_pkg.sv @@
// Package: shared types and constants of the grip stability window classifier.
package gswc_pkg;

    localparam int THR_W      = 19;
    localparam int MS_W       = 16;
    localparam int STEP_W     = 12;
    localparam int FORCE_W    = 15;
    localparam int TIME_W     = 32;
    localparam int IND_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int ONE_Q12 = 4096;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_CLEAR    = 1'b1;

    localparam logic [1:0] VERDICT_STABLE      = 2'd0;
    localparam logic [1:0] VERDICT_SLIP        = 2'd1;
    localparam logic [1:0] VERDICT_UNSTABLE    = 2'd2;
    localparam logic [1:0] VERDICT_STABLE_LATE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SUM_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_INTERVAL_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_STEP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CAP        = 3'd4;

    localparam logic [THR_W-1:0]   RST_SUM_THRESHOLD     = 19'd2458;
    localparam logic [MS_W-1:0]    RST_WINDOW_MS         = 16'd800;
    localparam logic [MS_W-1:0]    RST_RAISE_INTERVAL_MS = 16'd100;
    localparam logic [STEP_W-1:0]  RST_RAISE_STEP        = 12'd410;
    localparam logic [FORCE_W-1:0] RST_TARGET_CAP        = 15'd24576;

    typedef struct packed {
        logic                      opcode;
        logic signed [IND_W-1:0]   indicator;
        logic [TIME_W-1:0]         now_ms;
        logic                      raise_enable;
        logic [FORCE_W-1:0]        new_target;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         verdict;
        logic               stable_flag;
        logic [FORCE_W-1:0] target_force;
        logic               target_raised;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_item;

endpackage

@@ rtl/gswc_if.sv @@
// Interfaces: sample, result and configuration channels with valid/ready handshake.
interface gswc_in_if;
    import gswc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gswc_out_if;
    import gswc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gswc_cfg_if;
    import gswc_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/grip_stability_window_classifier.sv @@
// Top level: windowed grip stability classifier with rate-limited target force raise.
// The block takes one sample or clear transfer per clock while o_out is not stalled, and
// delivers each result through the input register and then the result register.
// Sustained rate is one item per cycle without back-pressure; the window sum is kept as a
// running total (subtract the oldest entry, add the newest), so each item needs a single
// subtract, add and compare. A clear transfer produces no result. Configuration writes are
// always accepted and apply to the next item classified. An unknown register index is ignored.
module grip_stability_window_classifier #(
    parameter int WINDOW_LEN = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gswc_in_if.sink   i_in,
    gswc_out_if.source o_out,
    gswc_cfg_if.sink  i_cfg
);
    import gswc_pkg::*;

    localparam int SUM_W = FORCE_W + $clog2(WINDOW_LEN);
    localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam logic [SUM_W-1:0] FILL_SUM = SUM_W'(WINDOW_LEN * ONE_Q12);
    localparam logic [FORCE_W-1:0] ONE_ENTRY = FORCE_W'(ONE_Q12);

    logic [THR_W-1:0]   r_sum_threshold;
    logic [MS_W-1:0]    r_window_ms;
    logic [MS_W-1:0]    r_raise_interval_ms;
    logic [STEP_W-1:0]  r_raise_step;
    logic [FORCE_W-1:0] r_target_cap;

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [FORCE_W-1:0] r_win [WINDOW_LEN];
    logic [FORCE_W-1:0] n_win [WINDOW_LEN];
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [TIME_W-1:0]  r_window_start_ms, n_window_start_ms;
    logic               r_overshoot, n_overshoot;
    logic [FORCE_W-1:0] r_force_target, n_force_target;
    logic [TIME_W-1:0]  r_last_raise_ms, n_last_raise_ms;
    logic               r_raise_armed, n_raise_armed;

    logic               w_advance;
    logic               w_fire;
    logic [FORCE_W-1:0] w_mag;
    logic [IND_W-1:0]   w_neg;
    logic [SUM_W-1:0]   w_sum_new;
    logic               w_stable;
    logic               w_inside;
    logic               w_positive;
    logic               w_rate_ok;
    logic [FORCE_W:0]   w_raise_sum;
    logic [FORCE_W-1:0] w_capped;
    logic [TIME_W-1:0]  w_win_age;
    logic [TIME_W-1:0]  w_raise_age;

    assign w_advance   = !r_out_valid || o_out.ready;
    assign w_fire      = r_in_valid && w_advance;
    assign i_in.ready  = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_neg      = -r_in.indicator;
    assign w_positive = !r_in.indicator[IND_W-1] && (r_in.indicator != '0);
    assign w_win_age   = r_in.now_ms - r_window_start_ms;
    assign w_raise_age = r_in.now_ms - r_last_raise_ms;
    assign w_inside    = w_win_age < {{(TIME_W-MS_W){1'b0}}, r_window_ms};
    assign w_rate_ok   = !(w_raise_age < {{(TIME_W-MS_W){1'b0}}, r_raise_interval_ms});
    assign w_raise_sum = {1'b0, r_force_target} + {{(FORCE_W+1-STEP_W){1'b0}}, r_raise_step};
    assign w_capped    = (w_raise_sum < {1'b0, r_target_cap}) ?
                         w_raise_sum[FORCE_W-1:0] : r_target_cap;

    always_comb begin
        if (!r_in.indicator[IND_W-1]) begin
            w_mag = r_in.indicator[FORCE_W-1:0];
        end else if (w_neg[IND_W-1]) begin
            w_mag = {FORCE_W{1'b1}};
        end else begin
            w_mag = w_neg[FORCE_W-1:0];
        end
    end

    assign w_sum_new = r_sum - {{(SUM_W-FORCE_W){1'b0}}, r_win[0]}
                     + {{(SUM_W-FORCE_W){1'b0}}, w_mag};
    assign w_stable  = CMP_W'(w_sum_new) < CMP_W'(r_sum_threshold);

    always_comb begin
        n_win             = r_win;
        n_sum             = r_sum;
        n_window_start_ms = r_window_start_ms;
        n_overshoot       = r_overshoot;
        n_force_target    = r_force_target;
        n_last_raise_ms   = r_last_raise_ms;
        n_raise_armed     = r_raise_armed;
        n_out_valid       = r_out_valid;
        n_out             = r_out;
        if (w_advance) begin
            n_out_valid = w_fire && (r_in.opcode == OP_CLASSIFY);
        end
        if (w_fire) begin
            if (r_in.opcode == OP_CLEAR) begin
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    n_win[i] = ONE_ENTRY;
                end
                n_sum             = FILL_SUM;
                n_window_start_ms = r_in.now_ms;
                n_force_target    = r_in.new_target;
            end else begin
                for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[WINDOW_LEN-1] = w_mag;
                n_sum = w_sum_new;
                n_out.target_raised = 1'b0;
                n_out.stable_flag   = w_stable;
                if (w_stable) begin
                    n_overshoot   = 1'b0;
                    n_out.verdict = VERDICT_STABLE;
                end else if (w_inside) begin
                    if (w_positive) begin
                        n_out.verdict = VERDICT_SLIP;
                        if (r_overshoot) begin
                            n_overshoot = 1'b0;
                        end else if (r_in.raise_enable) begin
                            if (!r_raise_armed) begin
                                n_raise_armed   = 1'b1;
                                n_last_raise_ms = r_in.now_ms;
                            end else if (w_rate_ok) begin
                                n_last_raise_ms     = r_in.now_ms;
                                n_force_target      = w_capped;
                                n_out.target_raised = 1'b1;
                            end
                        end
                    end else begin
                        n_overshoot   = 1'b1;
                        n_out.verdict = VERDICT_UNSTABLE;
                    end
                end else begin
                    n_window_start_ms = r_in.now_ms;
                    n_out.verdict     = VERDICT_STABLE_LATE;
                end
                n_out.target_force = n_force_target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_threshold     <= RST_SUM_THRESHOLD;
            r_window_ms         <= RST_WINDOW_MS;
            r_raise_interval_ms <= RST_RAISE_INTERVAL_MS;
            r_raise_step        <= RST_RAISE_STEP;
            r_target_cap        <= RST_TARGET_CAP;
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= ONE_ENTRY;
            end
            r_sum               <= FILL_SUM;
            r_window_start_ms   <= '0;
            r_overshoot         <= 1'b0;
            r_force_target      <= '0;
            r_last_raise_ms     <= '0;
            r_raise_armed       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.reg_index)
                    CFG_SUM_THRESHOLD:     r_sum_threshold <= i_cfg.data.wr_data;
                    CFG_WINDOW_MS:         r_window_ms <= i_cfg.data.wr_data[MS_W-1:0];
                    CFG_RAISE_INTERVAL_MS: r_raise_interval_ms <= i_cfg.data.wr_data[MS_W-1:0];
                    CFG_RAISE_STEP:        r_raise_step <= i_cfg.data.wr_data[STEP_W-1:0];
                    CFG_TARGET_CAP:        r_target_cap <= i_cfg.data.wr_data[FORCE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_out_valid       <= n_out_valid;
            r_win             <= n_win;
            r_sum             <= n_sum;
            r_window_start_ms <= n_window_start_ms;
            r_overshoot       <= n_overshoot;
            r_force_target    <= n_force_target;
            r_last_raise_ms   <= n_last_raise_ms;
            r_raise_armed     <= n_raise_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        r_out <= n_out;
    end

    a_clear_refills_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.opcode == OP_CLEAR) |=> (r_sum == FILL_SUM))
        else $error("window sum not refilled after clear");

    a_raise_only_on_slip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.target_raised) |-> (r_out.verdict == VERDICT_SLIP))
        else $error("target raised outside slip verdict");

    a_stable_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.stable_flag == (r_out.verdict == VERDICT_STABLE)))
        else $error("stable flag disagrees with verdict");

    a_raise_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.target_raised) |-> r_raise_armed)
        else $error("raise granted while unarmed");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

@@ test/gswc_checker.sv @@
`timescale 1ns / 1ps
// Checker: watches the sample, result and register channels, predicts each verdict and compares.
module gswc_checker #(
    parameter int WINDOW_LEN = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gswc_in_if   i_sample,
    gswc_out_if  i_result,
    gswc_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_raised
);
    import gswc_pkg::*;

    localparam int MAG_MAX = 2**FORCE_W - 1;

    logic [THR_W-1:0]   thr_q;
    logic [MS_W-1:0]    win_ms_q;
    logic [MS_W-1:0]    ival_q;
    logic [STEP_W-1:0]  step_q;
    logic [FORCE_W-1:0] cap_q;

    logic [FORCE_W-1:0] hist [WINDOW_LEN];
    logic [TIME_W-1:0]  win_start;
    logic               overshoot_q;
    logic [FORCE_W-1:0] force_q;
    logic [TIME_W-1:0]  last_raise;
    logic               armed;

    t_out_item verdicts_due [$];
    int        fails;
    int        checked;
    int        raised;

    function automatic logic grant_raise(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0]  since;
        logic [FORCE_W:0]   bumped;
        if (!armed) begin
            armed      = 1'b1;
            last_raise = now;
            return 1'b0;
        end
        since = now - last_raise;
        if (since < ival_q) return 1'b0;
        last_raise = now;
        bumped     = force_q + step_q;
        force_q    = (bumped < cap_q) ? bumped[FORCE_W-1:0] : cap_q;
        return 1'b1;
    endfunction

    function automatic void apply_sample(input t_in_item s);
        logic [IND_W:0]    mag;
        int unsigned       total;
        logic              positive;
        logic [TIME_W-1:0] age;
        t_out_item         r;
        if (s.opcode == OP_CLEAR) begin
            foreach (hist[k]) hist[k] = FORCE_W'(ONE_Q12);
            win_start = s.now_ms;
            force_q   = s.new_target;
            return;
        end
        mag = s.indicator[IND_W-1] ? ({1'b1, {IND_W{1'b0}}} - {1'b0, s.indicator})
                                   : {1'b0, s.indicator};
        if (mag > MAG_MAX) mag = (IND_W+1)'(MAG_MAX);
        total = 0;
        for (int k = 0; k < WINDOW_LEN - 1; k++) begin
            hist[k] = hist[k+1];
            total  += hist[k];
        end
        hist[WINDOW_LEN-1] = mag[FORCE_W-1:0];
        total += mag;
        positive = !s.indicator[IND_W-1] && (s.indicator != 0);
        age      = s.now_ms - win_start;
        r        = '0;
        r.stable_flag = (total < thr_q);
        if (r.stable_flag) begin
            overshoot_q = 1'b0;
            r.verdict   = VERDICT_STABLE;
        end else if (age < win_ms_q) begin
            if (positive) begin
                if (overshoot_q) overshoot_q = 1'b0;
                else if (s.raise_enable) r.target_raised = grant_raise(s.now_ms);
                r.verdict = VERDICT_SLIP;
            end else begin
                overshoot_q = 1'b1;
                r.verdict   = VERDICT_UNSTABLE;
            end
        end else begin
            win_start = s.now_ms;
            r.verdict = VERDICT_STABLE_LATE;
        end
        r.target_force = force_q;
        verdicts_due.push_back(r);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            thr_q       = RST_SUM_THRESHOLD;
            win_ms_q    = RST_WINDOW_MS;
            ival_q      = RST_RAISE_INTERVAL_MS;
            step_q      = RST_RAISE_STEP;
            cap_q       = RST_TARGET_CAP;
            foreach (hist[k]) hist[k] = FORCE_W'(ONE_Q12);
            win_start   = '0;
            overshoot_q = 1'b0;
            force_q     = '0;
            last_raise  = '0;
            armed       = 1'b0;
            verdicts_due.delete();
            fails       = 0;
            checked     = 0;
            raised      = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                got = i_result.data;
                if (verdicts_due.size() == 0) begin
                    fails++;
                    $error("result transfer with no expected verdict pending");
                end else begin
                    want = verdicts_due.pop_front();
                    checked++;
                    if (got.target_raised) raised++;
                    if (got.verdict !== want.verdict) begin
                        fails++;
                        $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
                    end
                    if (got.stable_flag !== want.stable_flag) begin
                        fails++;
                        $error("stable_flag: expected %0d, actual %0d",
                               want.stable_flag, got.stable_flag);
                    end
                    if (got.target_force !== want.target_force) begin
                        fails++;
                        $error("target_force: expected %0d, actual %0d",
                               want.target_force, got.target_force);
                    end
                    if (got.target_raised !== want.target_raised) begin
                        fails++;
                        $error("target_raised: expected %0d, actual %0d",
                               want.target_raised, got.target_raised);
                    end
                end
            end
            if (i_sample.valid && i_sample.ready) apply_sample(i_sample.data);
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.reg_index)
                    CFG_SUM_THRESHOLD:     thr_q    = i_cfg.data.wr_data[THR_W-1:0];
                    CFG_WINDOW_MS:         win_ms_q = i_cfg.data.wr_data[MS_W-1:0];
                    CFG_RAISE_INTERVAL_MS: ival_q   = i_cfg.data.wr_data[MS_W-1:0];
                    CFG_RAISE_STEP:        step_q   = i_cfg.data.wr_data[STEP_W-1:0];
                    CFG_TARGET_CAP:        cap_q    = i_cfg.data.wr_data[FORCE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= verdicts_due.size();
        o_checked    <= checked;
        o_raised     <= raised;
    end

endmodule

@@ test/tb_grip_stability_window_classifier.sv @@
`timescale 1ns / 1ps
// Testbench top: drives samples, register writes and back-pressure, then reports the verdict.
module tb_grip_stability_window_classifier;
    import gswc_pkg::*;

    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 240;
    localparam int DRAIN_TAIL  = 4;
    localparam int DRAIN_LIMIT = 100000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_TARGET_CAP + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

    typedef enum int {BURST_QUIET, BURST_SLIP, BURST_SWING, BURST_NOISE} t_burst;

    logic clk;
    logic rst_n;

    gswc_in_if  in_ch ();
    gswc_out_if out_ch ();
    gswc_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int checked;
    int raised_count;

    int                send_idle_pct;
    int                recv_stall_pct;
    int                thr_now;
    logic [TIME_W-1:0] clock_ms;
    t_burst            burst_kind;
    int                burst_left;
    int                n_samples;
    int                n_clears;

    grip_stability_window_classifier u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    gswc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_sample     (in_ch),
        .i_result     (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_raised     (raised_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_in_item sample_of(input logic op, input int ind,
                                           input logic [TIME_W-1:0] now, input logic en,
                                           input logic [FORCE_W-1:0] tgt);
        t_in_item it;
        it.opcode       = op;
        it.indicator    = IND_W'(ind);
        it.now_ms       = now;
        it.raise_enable = en;
        it.new_target   = tgt;
        return it;
    endfunction

    function automatic t_in_item next_sample();
        int unsigned roll;
        int unsigned lim;
        int          ind;
        if (burst_left == 0) begin
            burst_kind = t_burst'($urandom_range(3));
            burst_left = $urandom_range(4, 16);
        end
        burst_left--;
        roll = $urandom_range(99);
        if (roll < 70)      clock_ms += $urandom_range(60);
        else if (roll < 90) clock_ms += $urandom_range(400);
        else if (roll < 98) clock_ms += $urandom_range(3000);
        else                clock_ms = $urandom;
        if ($urandom_range(99) < 5)
            return sample_of(OP_CLEAR, $urandom, clock_ms, $urandom_range(1), 15'($urandom));
        lim = thr_now / 12;
        if (lim > 32767) lim = 32767;
        case (burst_kind)
            BURST_QUIET: ind = $urandom_range(lim);
            BURST_SLIP:  ind = ($urandom_range(7) == 0) ? -$urandom_range(32768)
                                                        : $urandom_range(1, 32767);
            BURST_SWING: ind = $urandom_range(1, 32767);
            default: begin
                case ($urandom_range(9))
                    0: ind = -32768;
                    1: ind = 32767;
                    2: ind = 0;
                    3: ind = -1;
                    default: ind = $urandom;
                endcase
            end
        endcase
        if (burst_kind != BURST_SLIP && burst_kind != BURST_NOISE && $urandom_range(1))
            ind = -ind;
        return sample_of(OP_CLASSIFY, ind, clock_ms, $urandom_range(9) != 0, 15'($urandom));
    endfunction

    task automatic send_item(input t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
        if (it.opcode == OP_CLEAR) n_clears++;
        else n_samples++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{reg_index: idx, wr_data: CFG_DATA_W'(val)};
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic program_regs(input int unsigned thr, input int unsigned win,
                                input int unsigned ival, input int unsigned step,
                                input int unsigned cap);
        put_reg(CFG_SUM_THRESHOLD, thr);
        put_reg(CFG_WINDOW_MS, win);
        put_reg(CFG_RAISE_INTERVAL_MS, ival);
        put_reg(CFG_RAISE_STEP, step);
        put_reg(CFG_TARGET_CAP, cap);
        put_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom);
        cfg_ch.valid <= 1'b0;
        thr_now = thr;
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    initial begin
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.data     <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        thr_now        = RST_SUM_THRESHOLD;
        clock_ms       = '0;
        burst_left     = 0;
        n_samples      = 0;
        n_clears       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: overshoot, arming, rate limit, cap, expiry, wrap
        send_item(sample_of(OP_CLASSIFY, 0, 0, 1, 15'($urandom)));
        send_item(sample_of(OP_CLASSIFY, 1000, 10, 1, 15'($urandom)));
        send_item(sample_of(OP_CLASSIFY, 1000, 20, 1, 15'($urandom)));
        send_item(sample_of(OP_CLASSIFY, 1000, 50, 1, 15'($urandom)));
        send_item(sample_of(OP_CLASSIFY, 1000, 130, 1, 15'($urandom)));
        send_item(sample_of(OP_CLEAR, 0, 200, 0, 15'h7fff));
        send_item(sample_of(OP_CLASSIFY, 5, 400, 1, 15'($urandom)));
        send_item(sample_of(OP_CLASSIFY, -32768, 500, 1, 15'($urandom)));
        send_item(sample_of(OP_CLASSIFY, 32767, 1100, 1, 15'($urandom)));
        send_item(sample_of(OP_CLASSIFY, -1, 1150, 0, 15'($urandom)));
        send_item(sample_of(OP_CLASSIFY, 7, 1200, 0, 15'($urandom)));
        send_item(sample_of(OP_CLASSIFY, 7, 1210, 0, 15'($urandom)));
        for (int k = 0; k < 10; k++)
            send_item(sample_of(OP_CLASSIFY, (k % 3 == 0) ? 0 : (k % 3 == 1) ? 100 : -100,
                                1220 + 10 * k, 1, 15'($urandom)));
        send_item(sample_of(OP_CLEAR, 0, 32'hffff_fff0, 0, 15'd100));
        send_item(sample_of(OP_CLASSIFY, 32767, 5, 1, 15'($urandom)));
        in_ch.valid <= 1'b0;
        clock_ms = 5;

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0, 7: program_regs(RST_SUM_THRESHOLD, RST_WINDOW_MS, RST_RAISE_INTERVAL_MS,
                                   RST_RAISE_STEP, RST_TARGET_CAP);
                1: program_regs(20000, 300, 20, 4095, 32767);
                2: program_regs(0, 65535, 0, 1, 0);
                3: program_regs(327670, 0, 65535, 0, 32767);
                5: program_regs(50000, 1000, 50, 2000, 30000);
                default: program_regs($urandom_range(327670), $urandom_range(2000),
                                      $urandom_range(300), $urandom_range(4095),
                                      $urandom_range(32767));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            repeat (PHASE_ITEMS) send_item(next_sample());
            in_ch.valid <= 1'b0;
        end

        settle();
        $display("Covered %0d classify and %0d clear transfers over %0d register settings.",
                 n_samples, n_clears, N_PHASES);
        $display("Checked %0d verdicts, %0d of them with a target force raise.",
                 checked, raised_count);
        if (pending != 0) $error("%0d expected verdicts never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ grip_stability_window_classifier.f @@
rtl/gswc_pkg.sv
rtl/gswc_if.sv
rtl/grip_stability_window_classifier.sv
test/gswc_checker.sv
test/tb_grip_stability_window_classifier.sv
